### design/bccd_pkg.sv
// ----------------------------------------------------------------------------
// bccd_pkg: shared types and constants for the click/hold detector
// Timer width, register indexes, gesture codes and phase codes.
// ----------------------------------------------------------------------------
package bccd_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int MAX_PRESSES = 3;
	localparam int CFG_WIDTH   = 16;
	localparam int CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

	typedef logic [TIMER_WIDTH-1:0] timer_t;
	typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
	typedef logic [CMP_WIDTH-1:0]   cmp_t;
	typedef logic [1:0]             gesture_t;
	typedef logic [1:0]             phase_t;
	typedef logic [1:0]             cfg_index_t;

	localparam timer_t TIMER_MAX = {TIMER_WIDTH{1'b1}};

	// register indexes
	localparam cfg_index_t REG_DEBOUNCE = 2'd0;
	localparam cfg_index_t REG_WINDOW   = 2'd1;
	localparam cfg_index_t REG_HOLD     = 2'd2;

	localparam cfg_word_t DEBOUNCE_RST = 16'd200;
	localparam cfg_word_t WINDOW_RST   = 16'd1000;
	localparam cfg_word_t HOLD_RST     = 16'd1000;

	// gesture codes
	localparam gesture_t GESTURE_SINGLE = 2'd0;
	localparam gesture_t GESTURE_DOUBLE = 2'd1;
	localparam gesture_t GESTURE_TRIPLE = 2'd2;
	localparam gesture_t GESTURE_HOLD   = 2'd3;

	// phase codes
	localparam phase_t PH_IDLE     = 2'd0;
	localparam phase_t PH_DEBOUNCE = 2'd1;
	localparam phase_t PH_SAMPLE   = 2'd2;
	localparam phase_t PH_WAIT     = 2'd3;

	localparam logic [1:0] PRESS_LIMIT = 2'(MAX_PRESSES);

	typedef struct packed {
		cfg_word_t debounce_ticks;
		cfg_word_t window_ticks;
		cfg_word_t hold_limit_ticks;
	} cfg_t;

	typedef struct packed {
		logic     valid;
		gesture_t gesture;
	} result_t;

	function automatic timer_t sat_inc(input timer_t v);
		return (v == TIMER_MAX) ? TIMER_MAX : v + timer_t'(1);
	endfunction

	function automatic cmp_t widen_timer(input timer_t v);
		return cmp_t'(v);
	endfunction

	function automatic cmp_t widen_cfg(input cfg_word_t v);
		return cmp_t'(v);
	endfunction

endpackage

### design/bccd_button_if.sv
// ----------------------------------------------------------------------------
// bccd_button_if: button sample channel
// One word per tick carrying the sampled button level.
// ----------------------------------------------------------------------------
interface bccd_button_if;
	logic valid;
	logic ready;
	logic button_pressed;

	modport source (output valid, output button_pressed, input ready);
	modport sink   (input valid, input button_pressed, output ready);
endinterface

### design/bccd_gesture_if.sv
// ----------------------------------------------------------------------------
// bccd_gesture_if: gesture result channel
// One word per detected gesture.
// ----------------------------------------------------------------------------
interface bccd_gesture_if;
	import bccd_pkg::*;
	logic     valid;
	logic     ready;
	gesture_t gesture;

	modport source (output valid, output gesture, input ready);
	modport sink   (input valid, input gesture, output ready);
endinterface

### design/bccd_in_stage.sv
// ----------------------------------------------------------------------------
// bccd_in_stage: input register
// Holds one accepted button sample until the detector consumes it.
// ----------------------------------------------------------------------------
module bccd_in_stage (
	input  logic        clk,
	input  logic        arst_n,
	bccd_button_if.sink button,
	input  logic        advance,
	output logic        valid_s1,
	output logic        level_s1
);
	logic accept;

	assign button.ready = !valid_s1 || advance;
	assign accept       = button.valid && button.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1 <= button.button_pressed;
		end
	end
endmodule

### design/bccd_fsm.sv
// ----------------------------------------------------------------------------
// bccd_fsm: gesture state machine
// Debounce, hold and window timers plus press counting, one tick per step.
// ----------------------------------------------------------------------------
module bccd_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             level,
	input  bccd_pkg::cfg_t   cfg,
	output bccd_pkg::result_t result
);
	import bccd_pkg::*;

	phase_t     phase_q, phase_d;
	logic       prev_q;
	timer_t     deb_q, deb_d;
	timer_t     win_q, win_d;
	timer_t     hold_q, hold_d;
	logic [1:0] press_q, press_d;

	logic   edge_det;
	logic   win_done;
	logic   deb_busy;
	timer_t hold_inc;

	assign edge_det = level && !prev_q;
	assign win_done = widen_timer(win_d) >= widen_cfg(cfg.window_ticks);
	assign deb_busy = (widen_timer(deb_q) < widen_cfg(cfg.debounce_ticks)) &&
	                  (deb_q != TIMER_MAX);
	// a sample right after debounce starts the hold count from zero
	assign hold_inc = sat_inc((phase_q == PH_DEBOUNCE) ? '0 : hold_q);

	always_comb begin
		phase_d        = phase_q;
		deb_d          = deb_q;
		win_d          = sat_inc(win_q);
		hold_d         = hold_q;
		press_d        = press_q;
		result.valid   = 1'b0;
		result.gesture = GESTURE_SINGLE;
		case (phase_q)
			PH_IDLE: begin
				win_d = win_q;
				if (edge_det) begin
					press_d = '0;
					win_d   = '0;
					deb_d   = '0;
					hold_d  = '0;
					phase_d = PH_DEBOUNCE;
				end
			end
			PH_DEBOUNCE, PH_SAMPLE: begin
				if (phase_q == PH_DEBOUNCE && deb_busy) begin
					deb_d = deb_q + timer_t'(1);
				end else if (level) begin
					hold_d  = hold_inc;
					phase_d = PH_SAMPLE;
					if (widen_timer(hold_inc) > widen_cfg(cfg.hold_limit_ticks)) begin
						result.valid   = 1'b1;
						result.gesture = GESTURE_HOLD;
						phase_d        = PH_IDLE;
					end
				end else begin
					hold_d  = (phase_q == PH_DEBOUNCE) ? '0 : hold_q;
					press_d = press_q + 2'd1;
					if (press_d >= PRESS_LIMIT || press_d == 2'd0 || win_done) begin
						result.valid   = 1'b1;
						result.gesture = press_d - 2'd1;
						phase_d        = PH_IDLE;
					end else begin
						phase_d = PH_WAIT;
					end
				end
			end
			PH_WAIT: begin
				if (edge_det) begin
					deb_d   = '0;
					phase_d = PH_DEBOUNCE;
				end else if (win_done) begin
					result.valid   = 1'b1;
					result.gesture = press_q - 2'd1;
					phase_d        = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			prev_q  <= 1'b0;
			deb_q   <= '0;
			win_q   <= '0;
			hold_q  <= '0;
			press_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			prev_q  <= level;
			deb_q   <= deb_d;
			win_q   <= win_d;
			hold_q  <= hold_d;
			press_q <= press_d;
		end
	end
endmodule

### design/bccd_out_stage.sv
// ----------------------------------------------------------------------------
// bccd_out_stage: result register
// Holds a gesture word until the sink takes it.
// ----------------------------------------------------------------------------
module bccd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  bccd_pkg::result_t   result,
	output logic                free,
	bccd_gesture_if.source      gesture_out
);
	import bccd_pkg::*;

	logic     valid_q;
	gesture_t gesture_q;

	assign free                = !valid_q || gesture_out.ready;
	assign gesture_out.valid   = valid_q;
	assign gesture_out.gesture = gesture_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load && result.valid) begin
			valid_q <= 1'b1;
		end else if (gesture_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && result.valid) begin
			gesture_q <= result.gesture;
		end
	end
endmodule

### design/button_click_count_and_hold_detector.sv
// Path: input register holds the button word, result register the gesture word.
// Throughput: one button word per cycle; the single input register and the single
// result register set this, stalling only while a gesture word waits at the output.
// Reset: arst_n clears the gesture state, both stage valids and loads the timing
// registers with debounce 200, window 1000 and hold limit 1000 ticks.
// ----------------------------------------------------------------------------
// button_click_count_and_hold_detector: top level
// Config registers, input register, gesture state machine and result register.
// ----------------------------------------------------------------------------
module button_click_count_and_hold_detector (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  bccd_pkg::cfg_index_t cfg_index,
	input  bccd_pkg::cfg_word_t  cfg_data,
	bccd_button_if.sink          button,
	bccd_gesture_if.source       result
);
	import bccd_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1;
	logic    level_s1;
	logic    out_free;
	logic    advance;
	result_t step_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= DEBOUNCE_RST;
			cfg_q.window_ticks     <= WINDOW_RST;
			cfg_q.hold_limit_ticks <= HOLD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ticks   <= cfg_data;
				REG_WINDOW:   cfg_q.window_ticks     <= cfg_data;
				REG_HOLD:     cfg_q.hold_limit_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// consume the held sample only when the result register can take its word
	assign advance = valid_s1 && out_free;

	bccd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.button   (button),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.level_s1 (level_s1)
	);

	bccd_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.level  (level_s1),
		.cfg    (cfg_q),
		.result (step_res)
	);

	bccd_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.result      (step_res),
		.free        (out_free),
		.gesture_out (result)
	);
endmodule

### design/bccd_checker.sv
// ----------------------------------------------------------------------------
// bccd_checker: port-level checks for the click/hold detector
// Output stall behavior, input backpressure and result origin.
// ----------------------------------------------------------------------------
module bccd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       button_valid,
	input logic       button_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [1:0] result_gesture
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("gesture word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_gesture))
		else $error("gesture changed while stalled");

	// the input side only stalls behind a waiting gesture word
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!button_ready |-> result_valid && !result_ready)
		else $error("input stalled without output backpressure");

	// a fresh gesture word comes from a button word accepted at the input handshake
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(button_valid && button_ready, 2))
		else $error("gesture word without a matching button word");
endmodule

bind button_click_count_and_hold_detector bccd_checker u_bccd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.button_valid   (button.valid),
	.button_ready   (button.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_gesture (result.gesture)
);
